>>> rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

>>> rtl/core/ple_pkg.sv
// Types and codes of the positional list engine.
// No dependencies; used by the stream interface users and the core.
package ple_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 5;

   localparam logic [OP_W-1:0] OP_GET    = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [POS_W-1:0]  position;
      logic [WORD_W-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   data_out;
      logic [STATUS_W-1:0] status;
      logic [TOTAL_W-1:0]  entry_total;
   } rsp_type;

endpackage

>>> rtl/core/ple_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type comes from ple_pkg at instantiation.
interface ple_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/positional_list_engine_core.sv
// Positional list engine: bounded ordered list with get, insert, remove, clear.
// Depends on ple_pkg, ple_stream_if and assert_macros.svh.
//
//   channel   direction  payload               transfer when
//   req_chan  in         operation/position/   valid && ready
//                        data_in
//   rsp_chan  out        data_out/status/      valid && ready
//                        entry_total
//
// Error or clear goes straight to the result; get reads first; remove shifts
// down, insert shifts up then writes. The single entry memory moves one word
// per cycle through its one read and one write port; that sets the shift length.
// Synchronous reset empties the list at once; the memory is not cleared.
// req_chan is ready only when the sequencer is idle. A finished result waits
// in its own stage until the result register is free, so a stalled rsp_chan
// holds back only the next request.
`include "assert_macros.svh"

module positional_list_engine_core #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input logic          clock,
   input logic          reset,
   ple_stream_if.sink   req_chan,
   ple_stream_if.source rsp_chan
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_GET       = 3'd1;
   localparam logic [2:0] S_RM_HEAD   = 3'd2;
   localparam logic [2:0] S_RM_SHIFT  = 3'd3;
   localparam logic [2:0] S_INS_SHIFT = 3'd4;
   localparam logic [2:0] S_INS_PUT   = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working registers of the current request
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [DATA_WIDTH-1:0]        word_ff, word_in;
   logic [ple_pkg::WORD_W-1:0]   res_data_ff, res_data_in;
   logic [ple_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   ple_pkg::rsp_type             rsp_payload_ff, rsp_payload_in;

   // entry memory, one write and one registered read per cycle
   logic [DATA_WIDTH-1:0] entry_store_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   logic             req_fire;
   logic             rsp_free;
   logic [CMP_W-1:0] req_pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] idx_ext;

   // terms for the checks
   logic in_rm_shift;
   logic full_reported;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   assign req_pos_ext = CMP_W'(req_chan.payload.position);
   assign cnt_ext     = CMP_W'(count_ff);
   assign pos_ext     = CMP_W'(pos_ff);
   assign idx_ext     = CMP_W'(idx_ff);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      idx_in         = idx_ff;
      word_in        = word_ff;
      res_data_in    = res_data_ff;
      res_status_in  = res_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rd_addr        = idx_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            // read the named entry speculatively; get and remove need it next
            rd_addr = IDX_W'(req_chan.payload.position);
            if (req_fire) begin
               pos_in        = IDX_W'(req_chan.payload.position);
               word_in       = DATA_WIDTH'(req_chan.payload.data_in);
               res_data_in   = '0;
               res_status_in = ple_pkg::ST_OK;
               unique case (req_chan.payload.operation)
                  ple_pkg::OP_GET: begin
                     if (req_pos_ext >= cnt_ext) begin
                        res_status_in = ple_pkg::ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_GET;
                     end
                  end
                  ple_pkg::OP_INSERT: begin
                     if (req_pos_ext > cnt_ext) begin
                        res_status_in = ple_pkg::ST_RANGE;
                        state_in      = S_DONE;
                     end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                        res_status_in = ple_pkg::ST_FULL;
                        state_in      = S_DONE;
                     end else if (req_pos_ext == cnt_ext) begin
                        state_in = S_INS_PUT;
                     end else begin
                        // open the gap from the top: fetch the last entry
                        rd_addr  = IDX_W'(cnt_ext - CMP_W'(1));
                        idx_in   = IDX_W'(count_ff);
                        state_in = S_INS_SHIFT;
                     end
                  end
                  ple_pkg::OP_REMOVE: begin
                     if (req_pos_ext >= cnt_ext) begin
                        res_status_in = ple_pkg::ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_RM_HEAD;
                     end
                  end
                  ple_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_GET: begin
            res_data_in = ple_pkg::WORD_W'(rd_data_ff);
            state_in    = S_DONE;
         end

         S_RM_HEAD: begin
            // capture the removed word, then pull the later entries down
            res_data_in = ple_pkg::WORD_W'(rd_data_ff);
            rd_addr     = IDX_W'(pos_ext + CMP_W'(1));
            idx_in      = pos_ff;
            if (pos_ext + CMP_W'(1) < cnt_ext) begin
               state_in = S_RM_SHIFT;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_RM_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            rd_addr = IDX_W'(idx_ext + CMP_W'(2));
            idx_in  = IDX_W'(idx_ext + CMP_W'(1));
            if (idx_ext + CMP_W'(2) >= cnt_ext) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_DONE;
            end
         end

         S_INS_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data_ff;
            rd_addr = IDX_W'(idx_ext - CMP_W'(2));
            idx_in  = IDX_W'(idx_ext - CMP_W'(1));
            if (idx_ext - CMP_W'(1) <= pos_ext) begin
               state_in = S_INS_PUT;
            end
         end

         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = word_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         S_DONE: begin
            // hold the result until the output register can take it
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.data_out    = res_data_ff;
               rsp_payload_in.status      = res_status_ff;
               rsp_payload_in.entry_total = ple_pkg::TOTAL_W'(count_ff);
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      idx_ff         <= idx_in;
      word_ff        <= word_in;
      res_data_ff    <= res_data_in;
      res_status_ff  <= res_status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_store_ff[rd_addr];
   end

   // checks
   assign in_rm_shift   = (state_ff == S_RM_SHIFT);
   assign full_reported = (state_ff == S_DONE) && (res_status_ff == ple_pkg::ST_FULL);

   `ASSERT_SYNC(a_count_bound, clock, reset, CMP_W'(count_ff) <= CMP_W'(CAPACITY))
   `ASSERT_SYNC(a_busy_after_req, clock, reset, req_fire |=> !req_chan.ready)
   `ASSERT_SYNC(a_rm_shift_in_list, clock, reset, in_rm_shift |-> (idx_ext + CMP_W'(1) < cnt_ext))
   `ASSERT_SYNC(a_full_means_cap, clock, reset, full_reported |-> (cnt_ext == CMP_W'(CAPACITY)))
   `ASSERT_ALWAYS(a_no_write_idle, clock, (state_ff == S_IDLE) |-> !wr_en)

endmodule

>>> tb/list_checker.sv
// Scoreboard for the positional list engine: predicts each result and compares.
// Depends on ple_pkg; watches both stream channels of the core.
module list_checker #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ple_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ple_pkg::rsp_type rsp_payload,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ple_pkg::WORD_W-1:0] list_words [CAPACITY];
   int                         list_length = 0;
   ple_pkg::rsp_type           awaited_results [$];
   int                         mismatches = 0;

   // Apply one request to the shadow list and return the result it gives.
   function automatic ple_pkg::rsp_type apply_list_op(input ple_pkg::req_type r);
      ple_pkg::rsp_type res;
      int               pos;
      res        = '0;
      res.status = ple_pkg::ST_OK;
      pos        = int'(r.position);
      case (r.operation)
         ple_pkg::OP_GET: begin
            if (pos >= list_length) res.status = ple_pkg::ST_RANGE;
            else res.data_out = list_words[pos];
         end
         ple_pkg::OP_INSERT: begin
            // range check takes precedence over the full check
            if (pos > list_length) begin
               res.status = ple_pkg::ST_RANGE;
            end else if (list_length >= CAPACITY) begin
               res.status = ple_pkg::ST_FULL;
            end else begin
               for (int i = list_length; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = r.data_in;
               list_length++;
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (pos >= list_length) begin
               res.status = ple_pkg::ST_RANGE;
            end else begin
               res.data_out = list_words[pos];
               for (int i = pos; i + 1 < list_length; i++) list_words[i] = list_words[i+1];
               list_length--;
            end
         end
         default: list_length = 0;
      endcase
      res.entry_total = list_length[ple_pkg::TOTAL_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string field,
                                  input logic [ple_pkg::WORD_W-1:0] got,
                                  input logic [ple_pkg::WORD_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      ple_pkg::rsp_type want;
      if (reset) begin
         list_length = 0;
         awaited_results.delete();
      end else begin
         // a result never belongs to a request taken at the same edge: pop first
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_payload.data_out, '0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_payload.data_out !== want.data_out)
                  report_mismatch("data_out", rsp_payload.data_out, want.data_out);
               if (rsp_payload.status !== want.status)
                  report_mismatch("status", ple_pkg::WORD_W'(rsp_payload.status),
                                  ple_pkg::WORD_W'(want.status));
               if (rsp_payload.entry_total !== want.entry_total)
                  report_mismatch("entry_total", ple_pkg::WORD_W'(rsp_payload.entry_total),
                                  ple_pkg::WORD_W'(want.entry_total));
            end
         end
         if (req_valid && req_ready) awaited_results.push_back(apply_list_op(req_payload));
      end
      pending_count <= awaited_results.size();
      fail_count    <= mismatches;
   end

endmodule

>>> tb/testbench.sv
// Top of the positional list engine testbench: clock, reset, stimulus, verdict.
// Depends on ple_pkg, ple_stream_if, positional_list_engine_core and list_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY         = 16;
   localparam int RANDOM_PER_PHASE = 284;
   localparam int CYCLE_LIMIT      = 400_000;
   localparam int LONG_HOLD_START  = 1200;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES      = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int tx_idle_pct = 14;
   int rx_idle_pct = 50;
   int cycle_count = 0;
   int fail_count;
   int pending_count;

   ple_stream_if #(.payload_type(ple_pkg::req_type)) req_if ();
   ple_stream_if #(.payload_type(ple_pkg::rsp_type)) rsp_if ();

   positional_list_engine_core #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (ple_pkg::WORD_W)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_payload   (req_if.payload),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_payload   (rsp_if.payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // Watchdog: a run that hangs on a handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic ple_pkg::req_type make_request(input logic [ple_pkg::OP_W-1:0] op,
                                                     input int pos,
                                                     input logic [ple_pkg::WORD_W-1:0] word);
      ple_pkg::req_type r;
      r.operation = op;
      r.position  = pos[ple_pkg::POS_W-1:0];
      r.data_in   = word;
      return r;
   endfunction

   // Random request: mostly positions near the live part of the list, with a
   // shifting insert share so that the list drifts between empty and full.
   function automatic ple_pkg::req_type random_request(input int insert_weight);
      int                         pick;
      int                         pos;
      logic [ple_pkg::OP_W-1:0]   op;
      logic [ple_pkg::WORD_W-1:0] word;
      pick = $urandom_range(99);
      if (pick < 3) op = ple_pkg::OP_CLEAR;
      else if (pick < 3 + insert_weight) op = ple_pkg::OP_INSERT;
      else if (pick % 2 == 0) op = ple_pkg::OP_GET;
      else op = ple_pkg::OP_REMOVE;
      if ($urandom_range(99) < 80) pos = $urandom_range(CAPACITY);
      else pos = $urandom_range(63);
      pick = $urandom_range(99);
      if (pick < 10) word = '0;
      else if (pick < 20) word = '1;
      else word = $urandom;
      return make_request(op, pos, word);
   endfunction

   // Offer one request, with a random idle gap first, and hold it until the
   // transfer. Valid stays high between back-to-back requests.
   task automatic offer_request(input ple_pkg::req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop valid and hold off until every awaited result has been taken.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Result side: random back-pressure, plus one long hold-off counted here,
   // long enough for the core to back up and stall its request channel.
   initial begin : receiver
      int rx_cycle;
      int hold_left;
      rx_cycle  = 0;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) rx_cycle++;
         if (rx_cycle == LONG_HOLD_START) hold_left = LONG_HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int insert_weight;
      int pos;
      logic [ple_pkg::WORD_W-1:0] word;
      insert_weight  = 40;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty list: clear with nothing held, reads and removes past the end,
      // insert beyond the count.
      offer_request(make_request(ple_pkg::OP_CLEAR, 0, '0));
      offer_request(make_request(ple_pkg::OP_GET, 0, '0));
      offer_request(make_request(ple_pkg::OP_REMOVE, 0, '0));
      offer_request(make_request(ple_pkg::OP_INSERT, 1, 32'h1234_5678));

      // Fill to capacity, inserting at the front, the end and the middle;
      // the first two words are the data extremes.
      for (int i = 0; i < CAPACITY; i++) begin
         if (i % 3 == 0) pos = 0;
         else if (i % 3 == 1) pos = i;
         else pos = i / 2;
         if (i == 0) word = '0;
         else if (i == 1) word = '1;
         else word = $urandom;
         offer_request(make_request(ple_pkg::OP_INSERT, pos, word));
      end

      // Full list: out of range wins over full, then full itself, then reads at the
      // last slot, just past it and at the top position; removes last and first, clear.
      offer_request(make_request(ple_pkg::OP_INSERT, CAPACITY + 1, '1));
      offer_request(make_request(ple_pkg::OP_INSERT, CAPACITY, '1));
      offer_request(make_request(ple_pkg::OP_GET, CAPACITY - 1, '0));
      offer_request(make_request(ple_pkg::OP_GET, CAPACITY, '0));
      offer_request(make_request(ple_pkg::OP_GET, 63, '0));
      offer_request(make_request(ple_pkg::OP_REMOVE, CAPACITY - 1, '0));
      offer_request(make_request(ple_pkg::OP_REMOVE, 0, '0));
      offer_request(make_request(ple_pkg::OP_CLEAR, 63, '1));

      // Random phases: sender idles lightly then heavily then not at all,
      // the receiver heavily then lightly then not at all; drain fully between phases.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 14;
               rx_idle_pct = 50;
            end
            1: begin
               tx_idle_pct = 50;
               rx_idle_pct = 14;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % 60 == 0) insert_weight = $urandom_range(20, 70);
            offer_request(random_request(insert_weight));
         end
         wait_drained();
      end

      // Let any late or stray result show itself before the verdict.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
